[rtl/core/psa_pkg.sv]
// ----------------------------------------------------------------------------
// PSI section assembler package
// Status codes, CRC constants and the byte-wide CRC-32/MPEG-2 update.
// ----------------------------------------------------------------------------
`default_nettype none

package psa_pkg;

    // Status carried with every section beat.
    typedef enum logic [1:0] {
        ST_DATA    = 2'd0,
        ST_OK      = 2'd1,
        ST_CRC_ERR = 2'd2,
        ST_LEN_ERR = 2'd3
    } t_status;

    localparam logic [31:0] CRC_INIT      = 32'hffff_ffff;
    localparam logic [31:0] CRC_POLY      = 32'h04c1_1db7;
    localparam logic [11:0] MAX_LEN_RESET = 12'd1020;

    // Offset from the section length field to the index of the last byte.
    localparam logic [12:0] LAST_OFFSET   = 13'd2;

    // Header byte positions within a section.
    localparam logic [12:0] IDX_LEN_HI    = 13'd1;
    localparam logic [12:0] IDX_LEN_LO    = 13'd2;

    // One byte of CRC-32/MPEG-2, MSB first, no reflection.
    function automatic logic [31:0] psa_crc_byte(input logic [31:0] crc_in,
                                                 input logic [7:0]  data);
        logic [31:0] crc;
        logic [7:0]  d;
        crc = crc_in;
        d   = data;
        for (int i = 0; i < 8; i++) begin
            if (d[7] ^ crc[31]) begin
                crc = {crc[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[30:0], 1'b0};
            end
            d = {d[6:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

[rtl/core/psa_in_if.sv]
// ----------------------------------------------------------------------------
// PSI section assembler input channel
// Valid/ready channel carrying one transport payload byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface psa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       unit_start;

    modport source (output valid, output data_byte, output unit_start, input ready);
    modport sink   (input valid, input data_byte, input unit_start, output ready);
endinterface

`default_nettype wire

[rtl/core/psa_out_if.sv]
// ----------------------------------------------------------------------------
// PSI section assembler output channel
// Valid/ready channel carrying one section byte and its status per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface psa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] section_byte;
    logic       section_last;
    logic [1:0] section_status;

    modport source (output valid, output section_byte, output section_last,
                    output section_status, input ready);
    modport sink   (input valid, input section_byte, input section_last,
                    input section_status, output ready);
endinterface

`default_nettype wire

[rtl/core/psi_section_assembler_crc_core.sv]
// ----------------------------------------------------------------------------
// PSI section assembler with CRC check
// Reassembles MPEG-2 PSI sections from payload bytes and checks CRC-32/MPEG-2.
// ----------------------------------------------------------------------------
// The block takes one payload byte per clock cycle unless the output stalls
// and returns at most one section beat per byte, in the next cycle, from a
// single output register. The pointer-field drop, header length capture and
// a full byte-wide CRC update all sit in one combinational step between the
// state registers and that output register, so the sustained rate is one
// byte per cycle whenever the sink keeps ready high. A new byte is taken
// whenever the output register is empty or being emptied in the same cycle.
// Dropped bytes (before a unit start, the pointer field and its skipped
// bytes) produce no beat. The last beat of a section carries OK, CRC error
// or length error, after which the block waits for the next unit start.
`default_nettype none

module psi_section_assembler_crc_core
    import psa_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_wr_en,
    input  wire [11:0] i_cfg_wr_data,
    psa_in_if.sink     i_in,
    psa_out_if.source  o_out
);

    // Configuration and section state.
    logic [11:0] r_max_len;
    logic        r_waiting,  n_waiting;
    logic [7:0]  r_discard,  n_discard;
    logic [12:0] r_taken,    n_taken;
    logic [11:0] r_len,      n_len;
    logic [31:0] r_crc,      n_crc;

    // Output register.
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte,  n_out_byte;
    logic        r_out_last,  n_out_last;
    t_status     r_out_stat,  n_out_stat;

    logic        in_fire;
    logic        load;
    logic [31:0] crc_upd;
    logic [11:0] len_cur;
    logic        is_last;
    t_status     stat;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    assign o_out.valid          = r_out_valid;
    assign o_out.section_byte   = r_out_byte;
    assign o_out.section_last   = r_out_last;
    assign o_out.section_status = r_out_stat;

    // Per-byte section logic: CRC step, length capture and end detection.
    always_comb begin
        crc_upd = psa_crc_byte(r_crc, i_in.data_byte);
        if (r_taken == IDX_LEN_HI) begin
            len_cur = {i_in.data_byte[3:0], 8'h00};
        end else if (r_taken == IDX_LEN_LO) begin
            len_cur = {r_len[11:8], i_in.data_byte};
        end else begin
            len_cur = r_len;
        end
        is_last = 1'b0;
        stat    = ST_DATA;
        if (r_taken == IDX_LEN_LO && len_cur > r_max_len) begin
            is_last = 1'b1;
            stat    = ST_LEN_ERR;
        end else if (r_taken >= IDX_LEN_LO && r_taken >= ({1'b0, len_cur} + LAST_OFFSET)) begin
            is_last = 1'b1;
            stat    = (crc_upd == '0) ? ST_OK : ST_CRC_ERR;
        end
    end

    // Next state for the section tracker and the output register.
    always_comb begin
        n_waiting   = r_waiting;
        n_discard   = r_discard;
        n_taken     = r_taken;
        n_len       = r_len;
        n_crc       = r_crc;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_stat  = r_out_stat;
        load        = 1'b0;
        if (in_fire) begin
            if (i_in.unit_start) begin
                n_waiting = 1'b0;
                n_discard = i_in.data_byte;
                n_taken   = '0;
                n_len     = '0;
                n_crc     = CRC_INIT;
            end else if (r_waiting) begin
                n_waiting = 1'b1;
            end else if (r_discard != '0) begin
                n_discard = r_discard - 8'd1;
            end else begin
                load = 1'b1;
                if (is_last) begin
                    n_waiting = 1'b1;
                    n_discard = '0;
                    n_taken   = '0;
                    n_len     = '0;
                    n_crc     = CRC_INIT;
                end else begin
                    n_taken = r_taken + 13'd1;
                    n_len   = len_cur;
                    n_crc   = crc_upd;
                end
            end
        end
        if (load) begin
            n_out_valid = 1'b1;
            n_out_byte  = i_in.data_byte;
            n_out_last  = is_last;
            n_out_stat  = stat;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= MAX_LEN_RESET;
            r_waiting   <= 1'b1;
            r_discard   <= '0;
            r_taken     <= '0;
            r_len       <= '0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            r_waiting   <= n_waiting;
            r_discard   <= n_discard;
            r_taken     <= n_taken;
            r_len       <= n_len;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_stat <= n_out_stat;
    end

`ifndef NO_ASSERTIONS
    // The last flag and a final status always travel together.
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last == (r_out_stat != ST_DATA)))
        else $error("section_last and section_status disagree");

    // A stalled beat stays in the output register unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out_byte)
            && $stable(r_out_last) && $stable(r_out_stat))
        else $error("stalled output beat was overwritten");

    // While waiting for a unit start the section counters are cleared.
    a_wait_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_waiting |-> (r_taken == '0) && (r_discard == '0) && (r_crc == CRC_INIT))
        else $error("section state not cleared while waiting");

    // The byte count never runs past the longest possible section.
    a_taken_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_taken <= 13'd4097)
        else $error("section byte count out of range");

    // A length error is only raised on the byte that completes the length.
    a_len_err_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && (stat == ST_LEN_ERR) |-> (r_taken == IDX_LEN_LO))
        else $error("length error raised away from the length byte");
`endif

endmodule

`default_nettype wire
